// ----- hw/rtl/b64enc_pkg.sv -----
// ----------------------------------------------------------------------------
// b64enc_pkg: shared types and constants of the streaming base64 encoder
// Holds the group descriptor that travels from the byte gatherer to the
// character generator, plus the alphabet and padding constants.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam int ALPHA_WORDS   = 8;
    localparam int ALPHA_WORD_W  = 64;
    localparam int ALPHA_SEL_W   = 3;
    localparam int CFG_INDEX_W   = 4;
    localparam int CHAR_W        = 8;
    localparam int SLICE_W       = 6;
    localparam int GROUP_W       = 24;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h2A;

    // One group of up to three bytes, already zero-filled to 24 bits.
    // nchars is the number of alphabet characters (2, 3 or 4); the rest
    // of the four output characters are padding.
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [2:0]         nchars;
        logic               eom;
    } grp_entry_t;

endpackage

// ----- hw/rtl/base64_stream_encoder_top.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder_top: streaming base64 encoder with loadable alphabet
// Bytes in, four characters out per three-byte group, padding on the end.
// ----------------------------------------------------------------------------
// Handoff: the first character of a group is offered after the transfer of the
// byte that closes the group, once its descriptor has passed through the queue,
// the work register and the output register. Throughput: one character per
// cycle while m_ready holds, set by the single alphabet lookup in the character generator.
// Reset (aresetn, synchronous, active low) clears the alphabet to zero, the
// partial group and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top
    import b64enc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration write port: index i selects alphabet word i.
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_wr_index,
    input  logic [ALPHA_WORD_W-1:0] cfg_wr_data,
    // Input byte stream.
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_data_byte,
    input  logic                    s_end_of_message,
    // Output character stream.
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CHAR_W-1:0]       m_out_char,
    output logic                    m_last_char
);

    // Descriptor handoff between the gatherer and the queue.
    logic       push;
    logic       push_ready;
    grp_entry_t push_entry;

    // Descriptor handoff between the queue and the character generator.
    logic       pop;
    logic       pop_valid;
    grp_entry_t pop_entry;

    // The front gathers bytes; it takes a transfer whenever the queue has
    // room, even while characters of earlier groups are still waiting.
    b64enc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_message (s_end_of_message),
        .push             (push),
        .push_entry       (push_entry),
        .queue_ready      (push_ready)
    );

    // Two group descriptors of slack between the two sides.
    b64enc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    // The back looks up one character per cycle unless the output is stalled,
    // and holds it in the output register until the downstream transfer completes.
    b64enc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .entry_valid  (pop_valid),
        .entry        (pop_entry),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_last_char  (m_last_char)
    );

endmodule

// ----- hw/rtl/b64enc_front.sv -----
// ----------------------------------------------------------------------------
// b64enc_front: byte gatherer
// Collects message bytes into 24-bit groups and issues one group descriptor
// per full group or per end of message.
// ----------------------------------------------------------------------------
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_message,
    output logic       push,
    output grp_entry_t push_entry,
    input  logic       queue_ready
);

    logic [15:0] held_bytes_reg;
    logic [15:0] held_bytes_next;
    logic [1:0]  held_count_reg;
    logic [1:0]  held_count_next;
    logic        accept;
    logic        complete;

    assign s_ready  = queue_ready;
    assign accept   = s_valid && s_ready;
    // A held count of three cannot occur; it completes the group like two.
    assign complete = held_count_reg[1] || s_end_of_message;
    assign push     = accept && complete;

    always_comb begin
        push_entry.eom = s_end_of_message;
        unique case (held_count_reg)
            2'd0: begin
                push_entry.group  = {s_data_byte, 16'h0000};
                push_entry.nchars = 3'd2;
            end
            2'd1: begin
                push_entry.group  = {held_bytes_reg[7:0], s_data_byte, 8'h00};
                push_entry.nchars = 3'd3;
            end
            default: begin
                push_entry.group  = {held_bytes_reg, s_data_byte};
                push_entry.nchars = 3'd4;
            end
        endcase
    end

    always_comb begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept) begin
            if (complete) begin
                held_bytes_next = '0;
                held_count_next = '0;
            end else begin
                held_bytes_next = {held_bytes_reg[7:0], s_data_byte};
                held_count_next = held_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bytes_reg <= '0;
            held_count_reg <= '0;
        end else begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

// ----- hw/rtl/b64enc_queue.sv -----
// ----------------------------------------------------------------------------
// b64enc_queue: group descriptor queue
// A short first-in first-out queue that lets the gatherer and the character
// generator stall independently.
// ----------------------------------------------------------------------------
module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  grp_entry_t push_entry,
    output logic       push_ready,
    input  logic       pop,
    output logic       pop_valid,
    output grp_entry_t pop_entry
);

    grp_entry_t             entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/b64enc_back.sv -----
// ----------------------------------------------------------------------------
// b64enc_back: character generator
// Holds the loadable alphabet and turns each group descriptor into four
// output characters through a registered output stage, one per cycle unless m_ready stalls it.
// ----------------------------------------------------------------------------
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_wr_index,
    input  logic [ALPHA_WORD_W-1:0] cfg_wr_data,
    input  logic                    entry_valid,
    input  grp_entry_t              entry,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CHAR_W-1:0]       m_out_char,
    output logic                    m_last_char
);

    logic [ALPHA_WORD_W-1:0] alpha_reg [ALPHA_WORDS];
    grp_entry_t              work_reg;
    logic                    active_reg;
    logic [1:0]              k_reg;
    logic                    m_valid_reg;
    logic [CHAR_W-1:0]       m_out_char_reg;
    logic                    m_last_char_reg;

    logic                    advance;
    logic [SLICE_W-1:0]      slice;
    logic [ALPHA_WORD_W-1:0] alpha_word;
    logic [CHAR_W-1:0]       char_next;
    logic                    last_next;

    assign advance = active_reg && (!m_valid_reg || m_ready);
    assign pop     = entry_valid && (!active_reg || (advance && (k_reg == 2'd3)));

    always_comb begin
        unique case (k_reg)
            2'd0:    slice = work_reg.group[23:18];
            2'd1:    slice = work_reg.group[17:12];
            2'd2:    slice = work_reg.group[11:6];
            default: slice = work_reg.group[5:0];
        endcase
    end

    assign alpha_word = alpha_reg[slice[SLICE_W-1:SLICE_W-ALPHA_SEL_W]];

    always_comb begin
        if ({1'b0, k_reg} < work_reg.nchars) begin
            char_next = alpha_word[{slice[2:0], 3'b000} +: CHAR_W];
        end else begin
            char_next = PAD_CHAR;
        end
        last_next = work_reg.eom && (k_reg == 2'd3);
    end

    // Alphabet words; indexes beyond the last word are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ALPHA_WORDS; i++) begin
                alpha_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (cfg_wr_index < CFG_INDEX_W'(ALPHA_WORDS))) begin
            alpha_reg[cfg_wr_index[ALPHA_SEL_W-1:0]] <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            work_reg <= entry;
        end
        if (advance) begin
            m_out_char_reg  <= char_next;
            m_last_char_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end else if (advance && (k_reg == 2'd3)) begin
                active_reg <= 1'b0;
            end else if (advance) begin
                k_reg <= k_reg + 2'd1;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_char  = m_out_char_reg;
    assign m_last_char = m_last_char_reg;

endmodule
